[hdl/tbdp_pkg.sv]
`timescale 1ns / 1ps

package tbdp_pkg;

   // Channel codes, also the bit positions in the enable register
   localparam logic [1:0] CH_ARM    = 2'd0;
   localparam logic [1:0] CH_DISARM = 2'd1;
   localparam logic [1:0] CH_ACK    = 2'd2;

   // Register indexes on the write port
   localparam logic [1:0] CSR_DEBOUNCE = 2'd0;
   localparam logic [1:0] CSR_ENABLE   = 2'd1;
   localparam logic [1:0] CSR_POLARITY = 2'd2;

   localparam int CSR_DATA_BITS = 16;
   localparam int STAMP_BITS    = 32;

   // Register reset values
   localparam logic [15:0] DEBOUNCE_RESET = 16'd50;
   localparam logic [2:0]  ENABLE_RESET   = 3'd4;
   localparam logic        POLARITY_RESET = 1'b1;

   // Per-channel sample request from the priority logic
   typedef struct packed {
      logic sample;   // channel is examined this instant: commit its update
      logic pressed;  // pressed level after polarity correction
   } chan_ctrl_type;

endpackage

[hdl/three_button_debounce_priority_unit.sv]
`timescale 1ns / 1ps

// Three-button debouncer with fixed priority (disarm, acknowledge, arm).
// Input channel req_*: one item is one sample instant carrying three raw pin
// levels and a wrapping millisecond time stamp. Result channel rsp_*: exactly
// one item per input item, holding event_valid and event_code.
// Write port csr_*: index 0 debounce time, 1 channel enable (bit0 arm, bit1
// disarm, bit2 acknowledge), 2 active-low polarity. Write only while idle.
// Throughput: one item per cycle unless the receiver stalls. An accepted
// item lands in the input register; when it advances, the per-channel
// compare/subtract logic runs, the channel state is committed and the
// result register is loaded, which offers the result on rsp_*. Each
// channel's state is read and written in the same cycle, which lets the
// next item follow directly.
// Reset: channels forget their first sample, registers return to debounce 50,
// only acknowledge enabled, active low. Both stages empty.
// Receiver stall: the result register holds; the input register still takes
// one more item, after which req_tready drops until the result drains.
module three_button_debounce_priority_unit
   import tbdp_pkg::*;
#(
   parameter int TIME_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   // request item
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // arm_level, disarm_level, ack_level, time_stamp[31:0]
   // result item
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // event_valid, event_code[1:0]
   // register writes
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   localparam int WIDE_BITS = (TIME_BITS > STAMP_BITS) ? TIME_BITS : STAMP_BITS;

   // Configuration registers
   logic [15:0] debounce_ff;
   logic [2:0]  enable_ff;
   logic        invert_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DEBOUNCE_RESET;
         enable_ff   <= ENABLE_RESET;
         invert_ff   <= POLARITY_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DEBOUNCE: debounce_ff <= csr_wdata[15:0];
            CSR_ENABLE:   enable_ff   <= csr_wdata[2:0];
            CSR_POLARITY: invert_ff   <= csr_wdata[0];
            default: ;   // drop writes past the last register
         endcase
      end
   end

   // Input register
   logic                  in_valid_ff, in_valid_in;
   logic [2:0]            levels_ff;     // [0] arm, [1] disarm, [2] ack
   logic [STAMP_BITS-1:0] stamp_ff;
   logic                  advance;

   // Result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic       ev_valid_ff, ev_valid_in;
   logic [1:0] ev_code_ff, ev_code_in;

   // Item moves from the input register into the result register
   assign advance     = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || advance;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         levels_ff <= req_tdata[2:0];
         stamp_ff  <= req_tdata[34:3];
      end
   end

   // Time stamp at the stored time width
   logic [WIDE_BITS-1:0] stamp_wide;
   logic [TIME_BITS-1:0] now;
   assign stamp_wide = WIDE_BITS'(stamp_ff);
   assign now        = stamp_wide[TIME_BITS-1:0];

   // Polarity correction: pressed level per channel
   logic [2:0] pressed;
   assign pressed = levels_ff ^ {3{invert_ff}};

   // Priority chain: a press on a higher channel stops lower ones from sampling
   logic [2:0]    press;
   logic [2:0]    sample;
   chan_ctrl_type ctrl [3];

   always_comb begin
      sample[CH_DISARM] = advance && enable_ff[CH_DISARM];
      sample[CH_ACK]    = advance && enable_ff[CH_ACK]
                          && !(sample[CH_DISARM] && press[CH_DISARM]);
      sample[CH_ARM]    = advance && enable_ff[CH_ARM]
                          && !(sample[CH_DISARM] && press[CH_DISARM])
                          && !(sample[CH_ACK] && press[CH_ACK]);
   end

   for (genvar g = 0; g < 3; g++) begin : g_chan
      assign ctrl[g].sample  = sample[g];
      assign ctrl[g].pressed = pressed[g];

      tbdp_chan #(
         .TIME_BITS (TIME_BITS)
      ) u_chan (
         .clock         (clock),
         .reset         (reset),
         .ctrl          (ctrl[g]),
         .now           (now),
         .debounce_time (debounce_ff),
         .press         (press[g])
      );
   end

   // Pick the reported event
   always_comb begin
      ev_valid_in = 1'b0;
      ev_code_in  = CH_ARM;
      if (sample[CH_DISARM] && press[CH_DISARM]) begin
         ev_valid_in = 1'b1;
         ev_code_in  = CH_DISARM;
      end else if (sample[CH_ACK] && press[CH_ACK]) begin
         ev_valid_in = 1'b1;
         ev_code_in  = CH_ACK;
      end else if (sample[CH_ARM] && press[CH_ARM]) begin
         ev_valid_in = 1'b1;
         ev_code_in  = CH_ARM;
      end
   end

   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ev_valid_ff <= ev_valid_in;
         ev_code_ff  <= ev_code_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, ev_code_ff, ev_valid_ff};

   // Checks
   a_no_event_code_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !ev_valid_ff |-> ev_code_ff == CH_ARM)
      else $error("result without event carries a nonzero code");

   a_one_press_taken: assert property (@(posedge clock) disable iff (reset)
      $onehot0(sample & press))
      else $error("more than one channel reported a press in one instant");

   a_event_enabled: assert property (@(posedge clock) disable iff (reset)
      advance && ev_valid_in |-> enable_ff[ev_code_in])
      else $error("event reported on a disabled channel");

   a_input_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff)
      else $error("stalled input item lost");

   a_sample_needs_item: assert property (@(posedge clock) disable iff (reset)
      |sample |-> advance)
      else $error("channel sampled without an item moving");

endmodule

[hdl/tbdp_chan.sv]
`timescale 1ns / 1ps

module tbdp_chan
   import tbdp_pkg::*;
#(
   parameter int TIME_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  chan_ctrl_type        ctrl,
   input  logic [TIME_BITS-1:0] now,
   input  logic [15:0]          debounce_time,
   output logic                 press
);

   localparam int CMP_BITS = (TIME_BITS > 16) ? TIME_BITS : 16;

   logic                 seen_ff,   seen_in;
   logic                 last_ff,   last_in;
   logic                 stable_ff, stable_in;
   logic [TIME_BITS-1:0] change_ff, change_in;

   logic                 level_change;
   logic [TIME_BITS-1:0] start_time;
   logic [TIME_BITS-1:0] elapsed;
   logic                 accept;

   always_comb begin
      level_change = (ctrl.pressed != last_ff);
      start_time   = level_change ? now : change_ff;
      elapsed      = now - start_time;
      accept       = seen_ff && (ctrl.pressed != stable_ff)
                     && (CMP_BITS'(elapsed) >= CMP_BITS'(debounce_time));
      press        = accept && ctrl.pressed;

      seen_in   = 1'b1;
      last_in   = ctrl.pressed;
      // First sample: take the level as stable and start the timer
      stable_in = (!seen_ff || accept) ? ctrl.pressed : stable_ff;
      change_in = seen_ff ? start_time : now;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else if (ctrl.sample) begin
         seen_ff <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.sample) begin
         last_ff   <= last_in;
         stable_ff <= stable_in;
         change_ff <= change_in;
      end
   end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;
   import tbdp_pkg::*;

   // One raw sample instant, packed in the order of req_tdata (arm in bit 0)
   typedef struct packed {
      bit [31:0] stamp;
      bit        ack;
      bit        disarm;
      bit        arm;
   } sample_type;

   // One debounced event, packed in the order of rsp_tdata (valid in bit 0)
   typedef struct packed {
      bit [1:0] code;
      bit       valid;
   } event_type;

   // Index past the last register: the block must ignore a write to it
   localparam logic [1:0] CSR_UNUSED    = 2'd3;
   // Event code carried when no press was detected
   localparam logic [1:0] NO_EVENT_CODE = 2'd0;
   // Fixed examination order of the channels
   localparam logic [1:0] SCAN_ORDER [3] = '{CH_DISARM, CH_ACK, CH_ARM};
   localparam int         HOLD_AFTER    = 300;   // events before the long receiver hold
   localparam int         HOLD_CYCLES   = 200;
   localparam int         WATCHDOG_MAX  = 2000;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [39:0]              req_tdata = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [7:0]               rsp_tdata;
   logic                     csr_we = 1'b0;
   logic [1:0]               csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   // Predictor copy of the registers
   bit [15:0] cfg_debounce;
   bit [2:0]  cfg_enable;
   bit        cfg_invert;

   // Predictor copy of the per-channel state, indexed by channel code
   bit        chan_seen   [3];
   bit        chan_last   [3];
   bit        chan_stable [3];
   bit [31:0] chan_since  [3];

   sample_type sample_q [$];     // samples waiting to be offered
   event_type  event_due_q [$];  // predicted events not yet returned

   sample_type offered;          // sample currently on req_tdata
   bit         idle_on = 1'b1;   // random idling on both sides
   int         send_gap = 0;
   int         recv_stall = 0;
   int         hold_left = 0;
   bit         hold_done = 1'b0;
   int         events_seen = 0;
   int         mismatches = 0;
   int         quiet_cycles = 0;
   event_type  got, want;

   three_button_debounce_priority_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // Return registers and channel state to their reset values
   task automatic clear_debouncer();
      cfg_debounce = DEBOUNCE_RESET;
      cfg_enable   = ENABLE_RESET;
      cfg_invert   = POLARITY_RESET;
      for (int c = 0; c < 3; c++) begin
         chan_seen[c]   = 1'b0;
         chan_last[c]   = 1'b0;
         chan_stable[c] = 1'b0;
         chan_since[c]  = '0;
      end
   endtask

   // Advance the channel state by one sample and return the event it causes.
   // Channels are scanned disarm, ack, arm; the first press stops the scan.
   function automatic event_type predict_event(sample_type s);
      bit [2:0]   pressed;
      bit [31:0]  elapsed;
      logic [1:0] ch;
      event_type  ev;
      bit         hit;
      pressed[CH_ARM]    = s.arm ^ cfg_invert;
      pressed[CH_DISARM] = s.disarm ^ cfg_invert;
      pressed[CH_ACK]    = s.ack ^ cfg_invert;
      ev.valid = 1'b0;
      ev.code  = NO_EVENT_CODE;
      hit = 1'b0;
      for (int k = 0; k < 3 && !hit; k++) begin
         ch = SCAN_ORDER[k];
         if (cfg_enable[ch]) begin
            if (!chan_seen[ch]) begin
               // first sample only records level and time
               chan_seen[ch]   = 1'b1;
               chan_last[ch]   = pressed[ch];
               chan_stable[ch] = pressed[ch];
               chan_since[ch]  = s.stamp;
            end else begin
               if (pressed[ch] != chan_last[ch]) begin
                  chan_last[ch]  = pressed[ch];
                  chan_since[ch] = s.stamp;
               end
               elapsed = s.stamp - chan_since[ch];
               if (pressed[ch] != chan_stable[ch] && elapsed >= {16'd0, cfg_debounce}) begin
                  chan_stable[ch] = pressed[ch];
                  // a release updates the stable level silently
                  if (pressed[ch]) begin
                     hit      = 1'b1;
                     ev.valid = 1'b1;
                     ev.code  = ch;
                  end
               end
            end
         end
      end
      return ev;
   endfunction

   task automatic push_sample(bit arm, bit disarm, bit ack, bit [31:0] stamp);
      sample_type s;
      s = '{stamp: stamp, ack: ack, disarm: disarm, arm: arm};
      sample_q = {sample_q, s};
   endtask

   // Hold until every queued sample is taken and every event has come back
   task automatic wait_drained();
      @(negedge clock);
      while (sample_q.size() != 0 || req_tvalid || event_due_q.size() != 0)
         @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write one register; the predictor masks the value the same way
   task automatic write_reg(logic [1:0] index, logic [CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (index)
         CSR_DEBOUNCE: cfg_debounce = value[15:0];
         CSR_ENABLE:   cfg_enable   = value[2:0];
         CSR_POLARITY: cfg_invert   = value[0];
         default: ;
      endcase
   endtask

   // Write all three registers, with junk in the unused upper bits
   task automatic set_config(bit [15:0] debounce, bit [2:0] enable, bit invert);
      write_reg(CSR_DEBOUNCE, debounce);
      write_reg(CSR_ENABLE, {13'($urandom), enable});
      write_reg(CSR_POLARITY, {15'($urandom), invert});
   endtask

   // Queue button sessions: levels held for runs, short bounces, time moving
   // forward in steps scaled to the debounce time, plus some raw noise.
   task automatic queue_sessions(int count, int noise_pct, bit near_wrap);
      bit [31:0] now;
      bit [31:0] span;
      bit [2:0]  held;
      bit [2:0]  lv;
      span = (cfg_debounce >> 2) + 1;
      now  = near_wrap ? 32'hFFFF_FFFF - $urandom_range(0, 16 * span + 64) : $urandom;
      held = 3'($urandom);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) < noise_pct) begin
            push_sample(1'($urandom), 1'($urandom), 1'($urandom), $urandom);
         end else begin
            now += $urandom_range(0, span);
            lv = held;
            for (int c = 0; c < 3; c++) begin
               if ($urandom_range(0, 9) == 0)
                  held[c] = ~held[c];
               lv[c] = held[c];
               if ($urandom_range(0, 11) == 0)
                  lv[c] = ~lv[c];   // one-sample bounce
            end
            push_sample(lv[CH_ARM], lv[CH_DISARM], lv[CH_ACK], now);
         end
      end
   endtask

   // Sender: offer queued samples, hold an item until accepted, idle in bursts
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready)
            event_due_q = {event_due_q, predict_event(offered)};
         if (!(req_tvalid && !req_tready)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (sample_q.size() > 0) begin
               if (idle_on && $urandom_range(0, 7) == 0) begin
                  send_gap = $urandom_range(1, 14) - 1;
                  req_tvalid <= 1'b0;
               end else begin
                  offered = sample_q.pop_front();
                  req_tdata  <= {5'd0, offered};
                  req_tvalid <= 1'b1;
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: check each event against the oldest prediction, stall in
   // bursts, and hold off once for a long stretch to back up the block
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[2:0];
            events_seen++;
            if (event_due_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected event: valid=%0d code=%0d", got.valid, got.code);
            end else begin
               want = event_due_q.pop_front();
               if (got.valid != want.valid || got.code != want.code) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("event %0d mismatch: expected valid=%0d code=%0d, got valid=%0d code=%0d",
                              events_seen, want.valid, want.code, got.valid, got.code);
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!hold_done && events_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_tready <= 1'b0;
         end else if (recv_stall > 0) begin
            recv_stall--;
            rsp_tready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            recv_stall = $urandom_range(1, 14) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: end the run when nothing moves on either side for too long
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   initial begin
      clear_debouncer();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: only ack enabled, active low, debounce 50.
      // First sample, release without event, then a clean ack press.
      push_sample(1'b0, 1'b0, 1'b0, 32'd0);
      push_sample(1'b1, 1'b1, 1'b1, 32'd10);
      push_sample(1'b1, 1'b1, 1'b1, 32'd60);
      push_sample(1'b0, 1'b0, 1'b0, 32'd61);
      push_sample(1'b0, 1'b0, 1'b0, 32'd110);
      push_sample(1'b0, 1'b0, 1'b0, 32'd111);
      wait_drained();

      // Zero debounce, all channels, active high; the unused index is ignored.
      // Presses on all three at once come out one per sample by priority.
      set_config(16'd0, 3'd7, 1'b0);
      write_reg(CSR_UNUSED, 16'hFFFF);
      push_sample(1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF);
      push_sample(1'b1, 1'b1, 1'b1, 32'd0);
      push_sample(1'b1, 1'b1, 1'b1, 32'd0);
      push_sample(1'b1, 1'b1, 1'b1, 32'd1);
      push_sample(1'b0, 1'b0, 1'b0, 32'd2);
      push_sample(1'b1, 1'b0, 1'b1, 32'd3);
      wait_drained();

      // Longest debounce across the time stamp wrap; ack disabled and held.
      set_config(16'hFFFF, 3'd3, 1'b1);
      push_sample(1'b1, 1'b1, 1'b1, 32'hFFFF_0000);
      push_sample(1'b0, 1'b0, 1'b1, 32'hFFFF_0001);
      push_sample(1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF);
      push_sample(1'b0, 1'b0, 1'b0, 32'h0000_0000);
      push_sample(1'b0, 1'b0, 1'b0, 32'h0000_0001);
      push_sample(1'b1, 1'b1, 1'b0, 32'h0001_0000);
      wait_drained();

      // Ack back on: it resumes with the state it held while disabled
      set_config(16'd0, 3'd4, 1'b1);
      push_sample(1'b1, 1'b1, 1'b0, 32'h8000_0000);
      push_sample(1'b1, 1'b1, 1'b1, 32'h8000_0000);
      wait_drained();

      // Random sessions under several settings
      set_config(16'd0, 3'd7, 1'b0);
      queue_sessions(150, 10, 1'b0);
      wait_drained();

      set_config(16'($urandom_range(1, 40)), 3'($urandom_range(1, 7)), 1'b1);
      queue_sessions(150, 10, 1'b0);
      wait_drained();

      set_config(16'($urandom), 3'd0, 1'($urandom));
      queue_sessions(20, 20, 1'b0);
      wait_drained();

      set_config(16'hFFFF, 3'd7, 1'b1);
      queue_sessions(150, 5, 1'b0);
      wait_drained();

      set_config(16'd50, 3'd7, 1'b0);
      queue_sessions(150, 5, 1'b1);
      wait_drained();

      set_config(16'($urandom_range(0, 300)), 3'($urandom_range(0, 7)), 1'($urandom));
      queue_sessions(150, 10, 1'b0);
      wait_drained();

      // Last part runs without idling on either side
      idle_on = 1'b0;
      set_config(16'($urandom_range(0, 100)), 3'd7, 1'($urandom));
      queue_sessions(160, 10, 1'b0);
      wait_drained();
      repeat (10) @(posedge clock);

      if (mismatches == 0 && event_due_q.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

[files.f]
hdl/tbdp_pkg.sv
hdl/tbdp_chan.sv
hdl/three_button_debounce_priority_unit.sv
bench/testbench.sv
